FILE: hdl/mse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants for the merge sort engine
// Buffer geometry, data width and the RAM write-port bundle.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Largest set the engine holds
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  // Counts run from 0 to DEPTH inclusive
  localparam int CNT_W  = ADDR_W + 1;
  localparam int DATA_W = 32;

  // Write port of one buffer RAM
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mse_wr_t;

endpackage : mse_pkg
`default_nettype wire

FILE: hdl/mse_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_if: valid/ready stream channels of the merge sort engine
// Input channel carries one unsorted value, output one sorted value.
// ----------------------------------------------------------------------------
interface mse_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source  (output valid, output value, output last, input ready);
  modport sink    (input valid, input value, input last, output ready);
  modport monitor (input valid, input value, input last, input ready);
endinterface : mse_in_if

interface mse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               sorted_last;

  modport source  (output valid, output sorted_value, output sorted_last, input ready);
  modport sink    (input valid, input sorted_value, input sorted_last, output ready);
  modport monitor (input valid, input sorted_value, input sorted_last, input ready);
endinterface : mse_out_if
`default_nettype wire

FILE: hdl/mse_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ram: one sort buffer
// DEPTH x DATA_W memory, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mse_ram
  import mse_pkg::*;
(
  input  wire  logic              clk,
  input  wire  mse_wr_t           wr,
  input  wire  logic [ADDR_W-1:0] rd_addr,
  output logic       [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : mse_ram
`default_nettype wire

FILE: hdl/merge_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sort_engine: streaming sorter for signed 32-bit values
// Collects a set, sorts it by bottom-up merging between two RAMs, emits it.
// ----------------------------------------------------------------------------
// Values are loaded one per cycle into buffer A until one arrives with last
// set, or until DEPTH (64) values are held. The set of n values is then sorted
// in ascending signed order with ceil(log2 n) merge passes that ping-pong
// between buffers A and B; ties keep input order. Each pass walks the run
// pairs in turn, and the merge refills the consumed head through the single
// registered read port of the source buffer. The sorted set is then emitted
// one value at a time, each held until it is taken, with sorted_last on the
// final value. Input ready is high only while a set is being loaded.
// ----------------------------------------------------------------------------
module merge_sort_engine
  import mse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mse_in_if.sink    in_ch,
  mse_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_PASS,
    S_PAIR,
    S_RD_L,
    S_RD_R,
    S_MERGE,
    S_FILL_L,
    S_FILL_R,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   width;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   hi;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   j;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   e;
  logic               sel;      // 0: A is source, 1: B is source
  logic signed [DATA_W-1:0] head_l;
  logic signed [DATA_W-1:0] head_r;
  logic               out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic               out_last;

  mse_wr_t            wr_a;
  mse_wr_t            wr_b;
  logic [CNT_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  rd_data_a;
  logic [DATA_W-1:0]  rd_data_b;
  logic signed [DATA_W-1:0] src_data;

  logic               in_fire;
  logic               out_fire;
  logic               left_ok;
  logic               right_ok;
  logic               take_left;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W:0]     hi_sum;
  logic [CNT_W-1:0]   mid_calc;
  logic [CNT_W-1:0]   hi_calc;
  logic signed [DATA_W-1:0] pick;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid && out_ch.ready;

  assign in_ch.ready         = (state == S_LOAD);
  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_value = out_value;
  assign out_ch.sorted_last  = out_last;

  assign src_data = sel ? $signed(rd_data_b) : $signed(rd_data_a);

  // Run bounds of the next pair, clipped to the set size
  assign mid_sum  = {1'b0, lo} + {1'b0, width};
  assign hi_sum   = mid_sum + {1'b0, width};
  assign mid_calc = (mid_sum > {1'b0, n}) ? n : mid_sum[CNT_W-1:0];
  assign hi_calc  = (hi_sum > {1'b0, n}) ? n : hi_sum[CNT_W-1:0];

  // Shared compare: pick the left head on ties
  assign left_ok   = (i < mid);
  assign right_ok  = (j < hi);
  assign take_left = left_ok && (!right_ok || (head_l <= head_r));
  assign pick      = take_left ? head_l : head_r;

  // Read address per state
  always_comb begin
    case (state)
      S_PAIR:      rd_addr = lo;
      S_RD_L:      rd_addr = j;
      S_MERGE:     rd_addr = take_left ? (i + CNT_W'(1)) : (j + CNT_W'(1));
      S_EMIT_RD:   rd_addr = e;
      S_EMIT_WAIT: rd_addr = e + CNT_W'(1);
      default:     rd_addr = i;
    endcase
  end

  // Write ports: loading fills A, merging writes the destination buffer
  always_comb begin
    wr_a = '0;
    wr_b = '0;
    if (state == S_LOAD) begin
      wr_a.en   = in_fire;
      wr_a.addr = cnt[ADDR_W-1:0];
      wr_a.data = in_ch.value;
    end else begin
      wr_a.addr = k[ADDR_W-1:0];
      wr_a.data = pick;
      wr_b.addr = k[ADDR_W-1:0];
      wr_b.data = pick;
      if (state == S_MERGE && (left_ok || right_ok)) begin
        wr_a.en = sel;
        wr_b.en = !sel;
      end
    end
  end

  mse_ram u_buf_a (
    .clk     (clk),
    .wr      (wr_a),
    .rd_addr (rd_addr[ADDR_W-1:0]),
    .rd_data (rd_data_a)
  );

  mse_ram u_buf_b (
    .clk     (clk),
    .wr      (wr_b),
    .rd_addr (rd_addr[ADDR_W-1:0]),
    .rd_data (rd_data_b)
  );

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (in_ch.last || (cnt == CNT_W'(DEPTH - 1))) begin
              n     <= cnt + CNT_W'(1);
              cnt   <= '0;
              width <= CNT_W'(1);
              sel   <= 1'b0;
              state <= S_PASS;
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        S_PASS: begin
          lo <= '0;
          if (width >= n) begin
            e     <= '0;
            state <= S_EMIT_RD;
          end else begin
            state <= S_PAIR;
          end
        end
        S_PAIR: begin
          mid   <= mid_calc;
          hi    <= hi_calc;
          i     <= lo;
          j     <= mid_calc;
          k     <= lo;
          state <= S_RD_L;
        end
        S_RD_L: begin
          head_l <= src_data;
          state  <= S_RD_R;
        end
        S_RD_R: begin
          head_r <= src_data;
          state  <= S_MERGE;
        end
        S_MERGE: begin
          if (!left_ok && !right_ok) begin
            // Pair done
            lo <= hi;
            if (hi >= n) begin
              sel   <= !sel;
              width <= {width[CNT_W-2:0], 1'b0};
              state <= S_PASS;
            end else begin
              state <= S_PAIR;
            end
          end else begin
            k <= k + CNT_W'(1);
            if (take_left) begin
              i     <= i + CNT_W'(1);
              state <= S_FILL_L;
            end else begin
              j     <= j + CNT_W'(1);
              state <= S_FILL_R;
            end
          end
        end
        S_FILL_L: begin
          head_l <= src_data;
          state  <= S_MERGE;
        end
        S_FILL_R: begin
          head_r <= src_data;
          state  <= S_MERGE;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_valid <= 1'b1;
          out_value <= src_data;
          out_last  <= (e + CNT_W'(1) == n);
          state     <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            e         <= e + CNT_W'(1);
            if (out_last) begin
              state <= S_LOAD;
            end else begin
              state <= S_EMIT_LD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule : merge_sort_engine
`default_nettype wire

FILE: hdl/mse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_checker: port-level checks for the merge sort engine
// Watches both channels; attached to every engine instance by bind.
// ----------------------------------------------------------------------------
module mse_checker
  import mse_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_last,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_sorted_value,
  input wire logic              out_sorted_last
);

  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is shown");

  // A closing transaction with last set drops input ready after it
  a_close_set: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still ready after set closed");

  // The final result ends the burst
  a_end_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_sorted_last) |=> !out_valid)
    else $error("result shown after the final one");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_sorted_value) && $stable(out_sorted_last)))
    else $error("stalled result changed");

  // Reset leaves the engine ready to load
  a_reset_ready: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("engine not ready after reset");

endmodule : mse_checker

bind merge_sort_engine mse_checker u_mse_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_last          (in_ch.last),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_sorted_value (out_ch.sorted_value),
  .out_sorted_last  (out_ch.sorted_last)
);
`default_nettype wire

FILE: tb/merge_sort_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine_test: self-checking bench for the merge sort engine
// Streams sets of signed values with random gaps on both channels, sorts each
// closed set in software and checks every sorted transaction in order.
// ----------------------------------------------------------------------------
module merge_sort_engine_test
  import mse_pkg::*;
();

  localparam int IDLE_PCT       = 23;
  localparam int DIRECTED_ITEMS = 15;
  localparam int RANDOM_ITEMS   = 215;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 64;

  typedef struct {
    int value;
    bit last;
  } sorted_item_t;

  // Sorted-order predictor plus the queue of transactions still owed
  class sort_scoreboard;
    int           open_set[$];
    sorted_item_t owed_q[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // Collect values; a set closes on last or when DEPTH values are held
    function void note_input(int value, bit last);
      int           keys[$];
      int           key;
      int           j;
      sorted_item_t item;
      open_set.push_back(value);
      if (!last && open_set.size() < DEPTH) return;
      keys = open_set;
      // stable insertion sort: equal keys keep arrival order
      for (int i = 1; i < keys.size(); i++) begin
        key = keys[i];
        j = i - 1;
        while (j >= 0 && keys[j] > key) begin
          keys[j + 1] = keys[j];
          j--;
        end
        keys[j + 1] = key;
      end
      for (int k = 0; k < keys.size(); k++) begin
        item.value = keys[k];
        item.last  = (k == keys.size() - 1);
        owed_q.push_back(item);
      end
      open_set.delete();
    endfunction

    function void check_result(int value, bit last);
      sorted_item_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected transaction, value %0d last %0b", $time, value, last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (value != want.value) begin
        $display("%0t: sorted_value expected %0d actual %0d", $time, want.value, value);
        errors++;
      end
      if (last != want.last) begin
        $display("%0t: sorted_last expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function bit drained();
      return owed_q.size() == 0 && open_set.size() == 0;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mse_in_if  in_ch ();
  mse_out_if out_ch ();

  merge_sort_engine uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sort_scoreboard sb;
  int items_sent   = 0;
  int results_seen = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mix of full-range values, small values for ties, and the extremes
  function automatic int pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      case ($urandom_range(3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 0;
        default: return -1;
      endcase
    end
    if (roll < 30) return $urandom_range(8) - 4;
    return $urandom();
  endfunction

  // One input transaction; entered and left at a falling edge
  task automatic send_item(input int value, input bit last);
    while (!(items_sent >= 120 && items_sent < 180) &&
           $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.last  <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(value, last);
    items_sent++;
    @(negedge clk);
  endtask

  // close = 0 lets the engine close the set itself at DEPTH values
  task automatic send_set(input int size, input bit close);
    for (int i = 0; i < size; i++) send_item(pick_value(), close && i == size - 1);
  endtask

  // Stimulus
  initial begin : stimulus
    bit paused;
    int roll;
    paused = 1'b0;
    sb = new();
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // single value
    send_item(32'sh1234_5678, 1'b1);
    // extremes, reversed
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b1);
    // ties
    send_item(5, 1'b0);
    send_item(-3, 1'b0);
    send_item(5, 1'b0);
    send_item(-3, 1'b1);
    // descending run
    send_item(100, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(-100, 1'b0);
    send_item(32'sh8000_0000, 1'b1);
    // zero, all ones, max
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(32'sh7fff_ffff, 1'b1);

    // set that fills without a last flag
    send_set(DEPTH, 1'b0);
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      // one pause at a set boundary until the engine has emitted everything
      if (!paused && items_sent >= 100) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (!sb.drained()) @(negedge clk);
      end
      roll = $urandom_range(99);
      if (roll < 8) send_set(DEPTH, 1'b0);
      else if (roll < 12) send_set(DEPTH, 1'b1);
      else send_set($urandom_range(12, 1), 1'b1);
    end
    in_ch.valid <= 1'b0;

    while (!sb.drained()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("merge_sort_engine_test: clean");
    end else begin
      $display("merge_sort_engine_test: errors");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off, checks each transaction
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= 60) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      out_ch.ready <= (results_seen >= 150 && results_seen < 260) ||
                      ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.sorted_value, out_ch.sorted_last);
        results_seen++;
      end
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin : watchdog
    #1_600_000;
    $display("merge_sort_engine_test: errors");
    $finish;
  end

endmodule

FILE: sim.f
hdl/mse_pkg.sv
hdl/mse_if.sv
hdl/mse_ram.sv
hdl/merge_sort_engine.sv
hdl/mse_checker.sv
tb/merge_sort_engine_test.sv
